[rtl/drdd_pkg.sv]
package drdd_pkg;
	localparam int RING = 6;
	localparam int ARM_W = 24;
	localparam int S_DATA_W = RING * ARM_W;
	localparam int M_DATA_W = 8;

	typedef enum logic [9:0] {
		ST_CLR  = 10'b0000000001,
		ST_IDLE = 10'b0000000010,
		ST_HASH = 10'b0000000100,
		ST_HREQ = 10'b0000001000,
		ST_HDAT = 10'b0000010000,
		ST_LINK = 10'b0000100000,
		ST_EREQ = 10'b0001000000,
		ST_CMP  = 10'b0010000000,
		ST_INS  = 10'b0100000000,
		ST_DONE = 10'b1000000000
	} state_t;

	typedef struct packed {
		logic found;
		logic full_res;
	} result_t;
endpackage

[rtl/drdd_ram.sv]
module drdd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic clk,
	input  logic we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[rtl/dihedral_ring_duplicate_detector.sv]
// Duplicate detector for six-value ring records, equal under rotation and reflection.
// Input channel s_*: one item is one record (arm_0..arm_5). Output channel m_*:
// exactly one result item per input item, found / full_res.
// The record is hashed as the sum of its arms modulo BUCKETS. That bucket's
// chain is walked in an entry RAM; each stored entry is compared in all six
// rotations, one rotation per cycle, clockwise and counter-clockwise together.
// A new record is pushed at its chain head unless CAPACITY entries are used.
// For a power-of-two BUCKETS the bucket is the low bits of the sum, else a
// reciprocal-multiply remainder. Every stored entry walked costs a link check,
// one entry-RAM read, a load step and up to six rotation compares; a match ends
// the walk early.
// One item is in work at a time; s_tready is high only when idle.
// A finished result waits in the output register; the next item is accepted
// meanwhile and its result is held back until the receiver takes the first.
// After reset the bucket-head RAM is cleared, one bucket per cycle over all BUCKETS
// buckets, and no item is accepted during that pass. The entry store is empty.
module dihedral_ring_duplicate_detector #(
	parameter int BUCKETS = 1024,
	parameter int CAPACITY = 1024,
	parameter int ARM_BITS = 24
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [drdd_pkg::S_DATA_W-1:0] s_tdata, // arm_0 .. arm_5, 24 bits each, arm_0 lowest
	output logic m_tvalid,
	input  logic m_tready,
	output logic [drdd_pkg::M_DATA_W-1:0] m_tdata  // found, full_res, 6 zero bits
);
	import drdd_pkg::*;

	localparam int BW = BUCKETS > 1 ? $clog2(BUCKETS) : 1;
	localparam int IW = CAPACITY > 1 ? $clog2(CAPACITY) : 1;
	localparam int PW = $clog2(CAPACITY + 1);
	localparam int SUM_W = ARM_BITS + 3;
	localparam int MW = SUM_W + 2;
	localparam int PRW = SUM_W + MW;
	localparam int SH = SUM_W + BW;
	localparam longint unsigned RECIP =
		((64'd1 << SH) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
	localparam int UB = ARM_BITS < ARM_W ? ARM_BITS : ARM_W;
	localparam bit POW2 = (1 << $clog2(BUCKETS)) == BUCKETS;
	localparam int EW = RING * ARM_BITS + PW;

	state_t state_q;
	logic [ARM_BITS-1:0] rec_q [RING];
	logic [ARM_BITS-1:0] rot_q [RING];
	logic [SUM_W-1:0] sum_q;
	logic [PRW-1:0] prod_q;
	logic hash_ph_q;
	logic [BW-1:0] bucket_q;
	logic [BW-1:0] clr_q;
	logic [PW-1:0] link_q, next_q, count_q;
	logic [2:0] rot_cnt_q;
	logic ent_load_q;
	result_t res_q, out_q;
	logic out_valid_q;

	logic [ARM_BITS-1:0] in_arm [RING];
	logic [SUM_W-1:0] in_sum;
	logic [SUM_W-1:0] quo, hash_rem;
	logic match;

	logic head_we;
	logic [BW-1:0] head_waddr;
	logic [PW-1:0] head_wdata, head_rdata;
	logic ent_we;
	logic [EW-1:0] ent_wdata, ent_rdata;
	logic [IW-1:0] ent_raddr;

	// Keep only the low ARM_BITS of each arm and add them up.
	always_comb begin
		in_sum = '0;
		for (int i = 0; i < RING; i++) begin
			in_arm[i] = ARM_BITS'(s_tdata[i*ARM_W +: UB]);
			in_sum = in_sum + SUM_W'(in_arm[i]);
		end
	end

	// Exact quotient from the reciprocal product, remainder by one subtract.
	always_comb begin
		quo = SUM_W'(prod_q >> SH);
		hash_rem = sum_q - SUM_W'(quo * SUM_W'(BUCKETS));
	end

	// rot_q[o] holds stored arm (o + s) mod 6; reflection reads index -o mod 6.
	always_comb begin
		logic cw, ccw;
		cw = 1'b1;
		ccw = 1'b1;
		for (int o = 0; o < RING; o++) begin
			if (rec_q[o] != rot_q[o]) cw = 1'b0;
			if (rec_q[o] != rot_q[(RING - o) % RING]) ccw = 1'b0;
		end
		match = cw | ccw;
	end

	assign head_we = (state_q == ST_CLR) ||
		(state_q == ST_INS && count_q < PW'(CAPACITY));
	assign head_waddr = (state_q == ST_CLR) ? clr_q : bucket_q;
	assign head_wdata = (state_q == ST_CLR) ? '0 : count_q + 1'b1;

	always_comb begin
		ent_wdata[RING*ARM_BITS +: PW] = link_q;
		for (int i = 0; i < RING; i++) begin
			ent_wdata[i*ARM_BITS +: ARM_BITS] = rec_q[i];
		end
	end
	assign ent_we = (state_q == ST_INS) && (count_q < PW'(CAPACITY));
	assign ent_raddr = IW'(link_q - 1'b1);

	drdd_ram #(.WIDTH(PW), .DEPTH(BUCKETS)) u_heads (
		.clk   (clk),
		.we    (head_we),
		.waddr (head_waddr),
		.wdata (head_wdata),
		.raddr (bucket_q),
		.rdata (head_rdata)
	);

	drdd_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_entries (
		.clk   (clk),
		.we    (ent_we),
		.waddr (IW'(count_q)),
		.wdata (ent_wdata),
		.raddr (ent_raddr),
		.rdata (ent_rdata)
	);

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata = {{(M_DATA_W-2){1'b0}}, out_q.full_res, out_q.found};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q <= '0;
			count_q <= '0;
			out_valid_q <= 1'b0;
			ent_load_q <= 1'b0;
		end else begin
			// Load a finished result when the register is free, drop it once taken.
			if (state_q == ST_DONE && (!out_valid_q || m_tready)) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == BW'(BUCKETS - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (s_tvalid) begin
						rec_q <= in_arm;
						sum_q <= in_sum;
						hash_ph_q <= 1'b0;
						if (POW2) begin
							bucket_q <= BUCKETS > 1 ? BW'(in_sum) : '0;
							state_q <= ST_HREQ;
						end else begin
							state_q <= ST_HASH;
						end
					end
				end
				ST_HASH: begin
					// Multiply by the reciprocal first, then take the remainder.
					if (!hash_ph_q) begin
						prod_q <= PRW'(sum_q) * PRW'(RECIP);
						hash_ph_q <= 1'b1;
					end else begin
						bucket_q <= BW'(hash_rem);
						state_q <= ST_HREQ;
					end
				end
				ST_HREQ: state_q <= ST_HDAT;
				ST_HDAT: begin
					link_q <= head_rdata;
					state_q <= ST_LINK;
				end
				ST_LINK: begin
					// End the walk at a null link or one past the used entries.
					if (link_q == '0 || link_q > count_q) begin
						link_q <= head_rdata;
						state_q <= ST_INS;
					end else begin
						state_q <= ST_EREQ;
						ent_load_q <= 1'b0;
					end
				end
				ST_EREQ: begin
					state_q <= ST_CMP;
					ent_load_q <= 1'b1;
				end
				ST_CMP: begin
					if (ent_load_q) begin
						ent_load_q <= 1'b0;
						for (int i = 0; i < RING; i++) begin
							rot_q[i] <= ent_rdata[i*ARM_BITS +: ARM_BITS];
						end
						next_q <= ent_rdata[RING*ARM_BITS +: PW];
						rot_cnt_q <= '0;
					end else if (match) begin
						res_q <= '{found: 1'b1, full_res: 1'b0};
						state_q <= ST_DONE;
					end else if (rot_cnt_q == 3'(RING - 1)) begin
						link_q <= next_q;
						state_q <= ST_LINK;
					end else begin
						// Advance one rotation.
						for (int i = 0; i < RING; i++) begin
							rot_q[i] <= rot_q[(i + 1) % RING];
						end
						rot_cnt_q <= rot_cnt_q + 1'b1;
					end
				end
				ST_INS: begin
					if (count_q < PW'(CAPACITY)) begin
						count_q <= count_q + 1'b1;
						res_q <= '{found: 1'b0, full_res: 1'b0};
					end else begin
						res_q <= '{found: 1'b0, full_res: 1'b1};
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					// Hold the result until the output register is free.
					if (!out_valid_q || m_tready) begin
						out_q <= res_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_CLR;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= PW'(CAPACITY))
		else $error("entry count past capacity");

	a_result_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(out_q.found && out_q.full_res))
		else $error("found and full together");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> $past(state_q == ST_INS))
		else $error("entry count moved outside insertion");

	a_ready_after_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLR) |-> !s_tready)
		else $error("item taken during clearing pass");
endmodule
